/* rtl/frrl_pkg.sv */
// Package for the frequency-ranked recent list.
// Holds the controller states, the datapath commands and the status bundle.
// No dependencies.
package frrl_pkg;

  localparam logic [16:0] AGE_LIMIT = 17'h08000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_ISSUE, ST_RD_WAIT, ST_S_CHK, ST_S_CMP, ST_AGE_RD, ST_AGE_WR,
    ST_MISS, ST_EV_CAP, ST_BUB_RD, ST_BUB_CMP, ST_DONE
  } frrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_RDIDX, CMD_RDRES, CMD_SRD, CMD_SINC, CMD_HIT,
    CMD_ARD, CMD_AWR, CMD_MISS, CMD_EVRD, CMD_EVCAP, CMD_BRD, CMD_SHIFT,
    CMD_PLACE, CMD_EMIT
  } frrl_cmd_e;

  typedef struct packed {
    logic is_read;
    logic last_i;
    logic match;
    logic overflow;
    logic full;
    logic p_zero;
    logic le;
    logic out_free;
  } frrl_stat_t;

endpackage

/* rtl/frrl_ctrl.sv */
// Controller for the frequency-ranked recent list.
// Sequences reads, search, ageing, eviction and bubble walk; depends on frrl_pkg.
module frrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  frrl_pkg::frrl_stat_t stat_i,
  output frrl_pkg::frrl_cmd_e  cmd_o
);
  import frrl_pkg::*;

  frrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_valid_i) state_d = ST_S_CHK;
      ST_S_CHK:    state_d = stat_i.is_read ? ST_RD_ISSUE :
                             (stat_i.last_i ? ST_MISS : ST_S_CMP);
      ST_RD_ISSUE: state_d = ST_RD_WAIT;
      ST_RD_WAIT:  state_d = ST_DONE;
      ST_S_CMP:    state_d = stat_i.match ? (stat_i.overflow ? ST_AGE_RD : ST_BUB_RD)
                                          : ST_S_CHK;
      ST_AGE_RD:   state_d = stat_i.last_i ? ST_BUB_RD : ST_AGE_WR;
      ST_AGE_WR:   state_d = ST_AGE_RD;
      ST_MISS:     state_d = stat_i.full ? ST_EV_CAP : ST_BUB_RD;
      ST_EV_CAP:   state_d = ST_BUB_RD;
      ST_BUB_RD:   state_d = stat_i.p_zero ? ST_DONE : ST_BUB_CMP;
      ST_BUB_CMP:  state_d = stat_i.le ? ST_BUB_RD : ST_DONE;
      ST_DONE:     if (stat_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = CMD_NONE;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o = CMD_LOAD;
      end
      ST_S_CHK:    if (!stat_i.is_read && !stat_i.last_i) cmd_o = CMD_SRD;
      ST_RD_ISSUE: cmd_o = CMD_RDIDX;
      ST_RD_WAIT:  cmd_o = CMD_RDRES;
      ST_S_CMP:    cmd_o = stat_i.match ? CMD_HIT : CMD_SINC;
      ST_AGE_RD:   if (!stat_i.last_i) cmd_o = CMD_ARD;
      ST_AGE_WR:   cmd_o = CMD_AWR;
      ST_MISS:     cmd_o = stat_i.full ? CMD_EVRD : CMD_MISS;
      ST_EV_CAP:   cmd_o = CMD_EVCAP;
      ST_BUB_RD:   cmd_o = stat_i.p_zero ? CMD_PLACE : CMD_BRD;
      ST_BUB_CMP:  cmd_o = stat_i.le ? CMD_SHIFT : CMD_PLACE;
      ST_DONE:     if (stat_i.out_free) cmd_o = CMD_EMIT;
      default:     cmd_o = CMD_NONE;
    endcase
  end

endmodule

/* rtl/frrl_dp.sv */
// Datapath for the frequency-ranked recent list: key and count memories,
// walk counters, result staging and output register; depends on frrl_pkg.
module frrl_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frrl_pkg::frrl_cmd_e  cmd_i,
  output frrl_pkg::frrl_stat_t stat_o,
  input  logic                 in_opcode_i,
  input  logic [31:0]          in_key_i,
  input  logic [5:0]           in_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [103:0]         out_data_o
);
  import frrl_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic [31:0]   keys_mem [ENTRIES];
  logic [15:0]   cnts_mem [ENTRIES];
  logic [31:0]   rd_key_q;
  logic [15:0]   rd_cnt_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wkey;
  logic [15:0]   wcnt;

  logic          op_q;
  logic [31:0]   k_q;
  logic [15:0]   c_q;
  logic [5:0]    idx_q;
  logic [CW-1:0] i_q, fill_q;
  logic [AW-1:0] found_q, p_q;

  logic          hit_q, aged_q, ev_q, val_q;
  logic [31:0]   evk_q, keyo_q;
  logic [15:0]   cnt_q;
  logic [5:0]    pos_q;

  logic          ovalid_q;
  logic [103:0]  odata_q;

  logic [16:0]   inc;
  logic [15:0]   halved;
  logic [AW+5:0] idx_wide, p_wide;
  logic [CW+5:0] idx_cmp, fill_cmp;
  logic [CW+6:0] fill_wide;

  assign inc       = {1'b0, rd_cnt_q} + 17'd1;
  assign halved    = (rd_cnt_q > 16'd1) ? (rd_cnt_q >> 1) : 16'd1;
  assign idx_wide  = {{AW{1'b0}}, idx_q};
  assign p_wide    = {6'd0, p_q};
  assign idx_cmp   = {{CW{1'b0}}, idx_q};
  assign fill_cmp  = {6'd0, fill_q};
  assign fill_wide = {7'd0, fill_q};

  always_comb begin
    stat_o.is_read  = op_q;
    stat_o.last_i   = (i_q == fill_q);
    stat_o.match    = (rd_key_q == k_q);
    stat_o.overflow = (inc > AGE_LIMIT);
    stat_o.full     = (fill_q >= FULL);
    stat_o.p_zero   = (p_q == '0);
    stat_o.le       = (rd_cnt_q <= c_q);
    stat_o.out_free = !ovalid_q || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = p_q;
    raddr = i_q[AW-1:0];
    wkey  = k_q;
    wcnt  = c_q;
    case (cmd_i)
      CMD_RDIDX: begin re = 1'b1; raddr = idx_wide[AW-1:0]; end
      CMD_SRD, CMD_ARD: re = 1'b1;
      CMD_AWR: begin
        we    = (i_q[AW-1:0] != found_q);
        waddr = i_q[AW-1:0];
        wkey  = rd_key_q;
        wcnt  = halved;
      end
      CMD_EVRD: begin re = 1'b1; raddr = LAST; end
      CMD_BRD: begin re = 1'b1; raddr = p_q - AW'(1); end
      CMD_SHIFT: begin we = 1'b1; wkey = rd_key_q; wcnt = rd_cnt_q; end
      CMD_PLACE: we = 1'b1;
      default: ;
    endcase
  end

  // Both memories share one write address and one read address; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we) begin
      keys_mem[waddr] <= wkey;
      cnts_mem[waddr] <= wcnt;
    end
    if (re) begin
      rd_key_q <= keys_mem[raddr];
      rd_cnt_q <= cnts_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q   <= in_opcode_i;
        k_q    <= in_key_i;
        idx_q  <= in_index_i;
        hit_q  <= 1'b0;
        aged_q <= 1'b0;
        ev_q   <= 1'b0;
        val_q  <= 1'b0;
        evk_q  <= '0;
        keyo_q <= '0;
        cnt_q  <= '0;
        pos_q  <= '0;
      end
      CMD_RDRES: begin
        if (idx_cmp < fill_cmp) begin
          val_q  <= 1'b1;
          keyo_q <= rd_key_q;
          cnt_q  <= rd_cnt_q;
        end
      end
      CMD_HIT: begin
        hit_q   <= 1'b1;
        found_q <= i_q[AW-1:0];
        p_q     <= i_q[AW-1:0];
        if (inc > AGE_LIMIT) begin
          aged_q <= 1'b1;
          c_q    <= inc[16:1];
        end else begin
          c_q <= inc[15:0];
        end
      end
      CMD_MISS: begin
        p_q <= fill_q[AW-1:0];
        c_q <= 16'd1;
      end
      CMD_EVCAP: begin
        p_q   <= LAST;
        c_q   <= 16'd1;
        ev_q  <= 1'b1;
        evk_q <= rd_key_q;
      end
      CMD_SHIFT: p_q <= p_q - AW'(1);
      CMD_PLACE: begin
        pos_q <= p_wide[5:0];
        cnt_q <= c_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      fill_q <= '0;
    end else begin
      case (cmd_i)
        CMD_LOAD, CMD_HIT: i_q <= '0;
        CMD_SINC, CMD_AWR: i_q <= i_q + CW'(1);
        CMD_MISS:          fill_q <= fill_q + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT) begin
      odata_q <= {7'd0, fill_wide[6:0], val_q, keyo_q, evk_q, ev_q, aged_q,
                  cnt_q, pos_q, hit_q};
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

/* rtl/frequency_ranked_recent_list.sv */
// Frequency-ranked recent list: a list of (key, count) pairs kept in order
// of descending count. Input and result are stream channels.
// The slave channel carries one command per transfer: tuser selects record
// (0) or read (1), tdata carries the key and the rank to read.
// The master channel returns exactly one result per command.
// A record searches the key memory one entry at a time, optionally
// sweeps every count once to halve it, then walks the touched entry
// forward one rank at a time.
// Only one command is worked on at a time; tready is high only while idle.
// The result is held in an output register, so a new command is taken while
// a finished result still waits; a stalled receiver holds the block in its
// final state until the register frees up.
// Reset empties the list at once; no clearing pass is needed, as a read of
// a rank at or above the fill level returns no entry.
module frequency_ranked_recent_list #(
  parameter int ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] key, [37:32] index, [39:38] zero
  input  logic [39:0]  s_axis_tdata,
  // [0] opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] hit, [6:1] position, [22:7] count_out, [23] aged, [24] evicted,
  // [56:25] evicted_key, [88:57] key_out, [89] entry_valid,
  // [96:90] occupancy, [103:97] zero
  output logic [103:0] m_axis_tdata
);
  import frrl_pkg::*;

  frrl_stat_t stat;
  frrl_cmd_e  cmd;

  frrl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  frrl_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_opcode_i (s_axis_tuser),
    .in_key_i    (s_axis_tdata[31:0]),
    .in_index_i  (s_axis_tdata[37:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
